// ===== rtl/ppa_pkg.sv =====
// Package for the permuted priority arbiter: field widths, register indexes
// and reset values shared by the arbiter RTL and its testbench. No dependencies.
package ppa_pkg;

    localparam int MASK_W    = 8;   // eligibility vector width
    localparam int REQ_W     = 3;   // requester number width
    localparam int COUNT_W   = 4;   // requester_count register width
    localparam int ORDER_W   = 24;  // packed permutation width
    localparam int CURSOR_W  = 3;   // cursor and reset_cursor width
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = ORDER_W;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 8;

    // Hardware never scans more than eight slots, whatever the requester count.
    localparam int SLOT_LIMIT         = 8;
    localparam int REQUESTERS_DEFAULT = 8;

    localparam logic                   POLICY_RESET = 1'b0;
    localparam logic [COUNT_W-1:0]     COUNT_RESET  = 4'd8;
    localparam logic [ORDER_W-1:0]     ORDER_RESET  = 24'd16434824;
    localparam logic [CURSOR_W-1:0]    CURSOR_RESET = 3'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY_MODE     = 2'd0,
        CFG_REQUESTER_COUNT = 2'd1,
        CFG_PRIORITY_ORDER  = 2'd2,
        CFG_RESET_CURSOR    = 2'd3
    } cfg_index_t;

    typedef enum logic {
        POLICY_FIXED       = 1'b0,
        POLICY_ROUND_ROBIN = 1'b1
    } policy_t;

endpackage

// ===== rtl/permuted_priority_arbiter_unit.sv =====
// Permuted priority arbiter top level: input register, single-pass grant
// selection and result register. Depends on ppa_pkg.
//
// Usage:
// - Slave stream (s_*) carries one eligibility vector per transaction; the
//   master stream (m_*) returns exactly one result per input transaction:
//   m_tuser flags a grant, m_tdata holds the granted requester number.
// - The search order is a permutation of slots, each naming a requester.
//   Fixed priority grants the first eligible requester in slot order; round
//   robin starts at the cursor slot and wraps within requester_count slots,
//   and a grant moves the cursor to the slot after the granted one.
// - Two register stages, input and result; the result register drives m_*.
//   One transaction is accepted every cycle unless a low m_tready stalls
//   the result register; the cursor update from one grant is ready for the
//   following item because selection and cursor update share one
//   combinational pass between the input and result registers.
// - When m_tready is low the result register holds, the input register fills,
//   and s_tready drops; no transaction is lost or repeated.
// - Reset (aresetn low, synchronous) empties both registers and returns all
//   configuration to its default; the cursor loads from reset_cursor there
//   and on every write of reset_cursor.
// - Configuration is written through cfg_wr_en/cfg_index/cfg_wr_data; the user
//   must write it only while the block is idle, which the block does not enforce.
module permuted_priority_arbiter_unit
    import ppa_pkg::*;
#(
    parameter int REQUESTERS = REQUESTERS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // [7:0] eligible_mask

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // [2:0] granted_requester, [7:3] zero
    output logic                   m_tuser    // [0] grant_valid
);

    localparam int SLOTS = (REQUESTERS < SLOT_LIMIT) ? REQUESTERS : SLOT_LIMIT;

    // Configuration and cursor state
    logic                  policy_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [ORDER_W-1:0]    order_reg;
    logic [CURSOR_W-1:0]   reset_cursor_reg;
    logic [CURSOR_W-1:0]   cursor_reg;
    logic [CURSOR_W-1:0]   cursor_next;

    // Pipeline registers
    logic                  in_valid_reg;
    logic [MASK_W-1:0]     in_mask_reg;
    logic                  out_valid_reg;
    logic                  out_grant_reg;
    logic [REQ_W-1:0]      out_req_reg;

    logic                  out_ready;
    logic                  in_move;

    // Selection signals
    logic [COUNT_W-1:0]    cnt_eff;
    logic [MASK_W-1:0]     mask_eff;
    logic [SLOTS-1:0]      hit;
    logic [CURSOR_W-1:0]   origin;
    logic                  hi_found;
    logic [CURSOR_W-1:0]   hi_pos;
    logic [CURSOR_W-1:0]   lo_pos;
    logic                  found;
    logic [CURSOR_W-1:0]   where_pos;
    logic [REQ_W-1:0]      who;
    logic [COUNT_W-1:0]    where_inc;

    assign out_ready = !out_valid_reg || m_tready;
    assign in_move   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_comb begin
        if (count_reg == '0) begin
            cnt_eff = COUNT_W'(1);
        end else if (count_reg > COUNT_W'(SLOTS)) begin
            cnt_eff = COUNT_W'(SLOTS);
        end else begin
            cnt_eff = count_reg;
        end
    end

    // Requesters at or above the effective count never win.
    always_comb begin
        for (int r = 0; r < MASK_W; r++) begin
            mask_eff[r] = in_mask_reg[r] && (COUNT_W'(r) < cnt_eff);
        end
    end

    always_comb begin
        for (int p = 0; p < SLOTS; p++) begin
            hit[p] = (COUNT_W'(p) < cnt_eff) && mask_eff[order_reg[REQ_W*p +: REQ_W]];
        end
    end

    always_comb begin
        if (policy_reg == POLICY_ROUND_ROBIN && COUNT_W'(cursor_reg) < cnt_eff) begin
            origin = cursor_reg;
        end else begin
            origin = '0;
        end
    end

    // Round-robin scan: the lowest hit at or after the origin wins, otherwise
    // the scan wraps and the lowest hit overall wins.
    always_comb begin
        hi_found = 1'b0;
        hi_pos   = '0;
        lo_pos   = '0;
        for (int p = SLOTS - 1; p >= 0; p--) begin
            if (hit[p]) begin
                lo_pos = CURSOR_W'(p);
                if (CURSOR_W'(p) >= origin) begin
                    hi_found = 1'b1;
                    hi_pos   = CURSOR_W'(p);
                end
            end
        end
        found     = |hit;
        where_pos = hi_found ? hi_pos : lo_pos;
        who       = order_reg[REQ_W*where_pos +: REQ_W];
        where_inc = COUNT_W'(where_pos) + COUNT_W'(1);
    end

    always_comb begin
        cursor_next = cursor_reg;
        if (in_move && found && policy_reg == POLICY_ROUND_ROBIN) begin
            cursor_next = (where_inc >= cnt_eff) ? '0 : where_inc[CURSOR_W-1:0];
        end
        if (cfg_wr_en && cfg_index == CFG_RESET_CURSOR) begin
            cursor_next = cfg_wr_data[CURSOR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg       <= POLICY_RESET;
            count_reg        <= COUNT_RESET;
            order_reg        <= ORDER_RESET;
            reset_cursor_reg <= CURSOR_RESET;
            cursor_reg       <= CURSOR_RESET;
        end else begin
            cursor_reg <= cursor_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_POLICY_MODE:     policy_reg       <= cfg_wr_data[0];
                    CFG_REQUESTER_COUNT: count_reg        <= cfg_wr_data[COUNT_W-1:0];
                    CFG_PRIORITY_ORDER:  order_reg        <= cfg_wr_data[ORDER_W-1:0];
                    CFG_RESET_CURSOR:    reset_cursor_reg <= cfg_wr_data[CURSOR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mask_reg <= s_tdata[MASK_W-1:0];
        end
        if (in_move) begin
            out_grant_reg <= found;
            out_req_reg   <= found ? who : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_grant_reg;
    assign m_tdata  = {{(TDATA_OUT_W - REQ_W){1'b0}}, out_req_reg};

    // An empty result register always lets the input side move on.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with an empty result register");

    // Fixed priority never moves the cursor.
    a_fixed_keeps_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        in_move && policy_reg == POLICY_FIXED && !cfg_wr_en |=> $stable(cursor_reg))
        else $error("cursor moved in fixed-priority mode");

    // A round-robin grant leaves the cursor inside the active slot range.
    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        in_move && found && policy_reg == POLICY_ROUND_ROBIN && !cfg_wr_en
        |=> COUNT_W'(cursor_reg) < cnt_eff)
        else $error("cursor left the active slot range");

    // A reported requester is always one that was eligible and in range.
    a_grant_eligible: assert property (@(posedge aclk) disable iff (!aresetn)
        in_move && found |-> mask_eff[who])
        else $error("granted requester was not eligible");

    // Reset-cursor writes reload the cursor.
    a_cursor_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en && cfg_index == CFG_RESET_CURSOR
        |=> cursor_reg == reset_cursor_reg)
        else $error("cursor not reloaded from reset_cursor");

endmodule

// ===== tb/permuted_priority_arbiter_checker.sv =====
// Checker for the permuted priority arbiter: follows the configuration port and both
// streams, predicts each grant on its own copy of the registers and cursor, and compares.
// Depends on ppa_pkg.
module permuted_priority_arbiter_checker
    import ppa_pkg::*;
#(
    parameter int REQUESTERS = REQUESTERS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [TDATA_OUT_W-1:0] m_tdata,
    input  logic                   m_tuser,
    output int                     mismatch_count,
    output int                     grants_outstanding,
    output int                     results_checked,
    output int                     grants_seen
);

    typedef struct packed {
        logic             valid;
        logic [REQ_W-1:0] who;
    } grant_t;

    localparam int SCAN_MAX = (REQUESTERS < SLOT_LIMIT) ? REQUESTERS : SLOT_LIMIT;

    policy_t             mode;
    logic [COUNT_W-1:0]  count_reg;
    logic [ORDER_W-1:0]  order_reg;
    logic [CURSOR_W-1:0] home_cursor;
    logic [CURSOR_W-1:0] cursor;
    logic [CURSOR_W-1:0] next_cursor;

    grant_t expected_grants[$];
    grant_t predicted;
    grant_t oldest;

    // Scans the permuted slots for the first eligible requester. The cursor only
    // moves on a round-robin grant.
    function automatic grant_t predict_grant(input logic [MASK_W-1:0] eligible,
                                             output logic [CURSOR_W-1:0] cursor_after);
        int               n;
        int               origin;
        int               pos;
        logic [MASK_W-1:0] live;
        logic [REQ_W-1:0] r;
        grant_t           g;
        if (count_reg == '0)
            n = 1;
        else if (int'(count_reg) > SCAN_MAX)
            n = SCAN_MAX;
        else
            n = int'(count_reg);
        live = eligible & MASK_W'((1 << n) - 1);
        origin = 0;
        if (mode == POLICY_ROUND_ROBIN && int'(cursor) < n)
            origin = int'(cursor);
        g = '0;
        cursor_after = cursor;
        for (int k = 0; k < n; k++) begin
            pos = origin + k;
            if (pos >= n)
                pos -= n;
            r = order_reg[REQ_W*pos +: REQ_W];
            if (!g.valid && live[r]) begin
                g.valid = 1'b1;
                g.who = r;
                if (mode == POLICY_ROUND_ROBIN)
                    cursor_after = CURSOR_W'((pos + 1 >= n) ? 0 : pos + 1);
            end
        end
        return g;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            mode        = POLICY_FIXED;
            count_reg   = COUNT_RESET;
            order_reg   = ORDER_RESET;
            home_cursor = CURSOR_RESET;
            cursor      = CURSOR_RESET;
            expected_grants.delete();
            mismatch_count  = 0;
            results_checked = 0;
            grants_seen     = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_index))
                    CFG_POLICY_MODE:     mode = policy_t'(cfg_wr_data[0]);
                    CFG_REQUESTER_COUNT: count_reg = cfg_wr_data[COUNT_W-1:0];
                    CFG_PRIORITY_ORDER:  order_reg = cfg_wr_data[ORDER_W-1:0];
                    CFG_RESET_CURSOR: begin
                        home_cursor = cfg_wr_data[CURSOR_W-1:0];
                        cursor = home_cursor;
                    end
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predicted = predict_grant(s_tdata[MASK_W-1:0], next_cursor);
                cursor = next_cursor;
                expected_grants = {expected_grants, predicted};
            end
            if (m_tvalid && m_tready) begin
                results_checked++;
                if (m_tuser)
                    grants_seen++;
                if (expected_grants.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transaction: tuser %0d tdata 0x%02h",
                                 m_tuser, m_tdata);
                end else begin
                    oldest = expected_grants.pop_front();
                    if (m_tuser !== oldest.valid ||
                        m_tdata !== TDATA_OUT_W'(oldest.who)) begin
                        mismatch_count++;
                        // Both sides print as grant flag / requester.
                        if (mismatch_count <= 10)
                            $display("grant mismatch: expected %0d/%0d got %0d/0x%02h",
                                     oldest.valid, oldest.who, m_tuser, m_tdata);
                    end
                end
            end
        end
        grants_outstanding = expected_grants.size();
    end

endmodule

// ===== tb/permuted_priority_arbiter_unit_tb.sv =====
// Top of the permuted priority arbiter testbench: clock, reset, register programming,
// eligibility stimulus and result back-pressure. Depends on ppa_pkg, the arbiter and
// permuted_priority_arbiter_checker.
module permuted_priority_arbiter_unit_tb;
    import ppa_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 14;
    localparam int ITEMS_PER_PHASE = 128;
    localparam int SETTLE_CYCLES   = 4;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tuser;

    int mismatch_count;
    int grants_outstanding;
    int results_checked;
    int grants_seen;
    int masks_sent;
    int cycle_count;
    int stall_left;
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_request;

    permuted_priority_arbiter_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    permuted_priority_arbiter_checker scoreboard (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wr_data        (cfg_wr_data),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .m_tuser            (m_tuser),
        .mismatch_count     (mismatch_count),
        .grants_outstanding (grants_outstanding),
        .results_checked    (results_checked),
        .grants_seen        (grants_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("permuted_priority_arbiter_unit_tb NOT OK");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left = 300;
                m_tready = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 13);
                m_tready = 1'b0;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic offer_mask(input logic [MASK_W-1:0] mask);
        int gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                s_tdata = TDATA_IN_W'($urandom);
            end
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = mask;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        masks_sent++;
    endtask

    // Registers change only once every grant in flight has come back.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (grants_outstanding != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // kind 0: shuffle of all eight requesters; kind 1: the first n slots hold a
    // shuffle of requesters below n; otherwise any 24 bits, repeats allowed.
    function automatic logic [ORDER_W-1:0] make_order(input int n, input int kind);
        int               perm[SLOT_LIMIT];
        int               top;
        int               j;
        int               t;
        logic [ORDER_W-1:0] word;
        if (kind > 1)
            return ORDER_W'($urandom);
        for (int i = 0; i < SLOT_LIMIT; i++)
            perm[i] = i;
        top = (kind == 0) ? SLOT_LIMIT - 1 : n - 1;
        for (int i = top; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (int i = 0; i < SLOT_LIMIT; i++)
            word[REQ_W*i +: REQ_W] = REQ_W'(perm[i]);
        return word;
    endfunction

    function automatic logic [MASK_W-1:0] random_mask();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return MASK_W'($urandom);
        else if (pick < 15)
            return MASK_W'(1 << $urandom_range(0, MASK_W - 1));
        else if (pick < 17)
            return '0;
        else
            return ~MASK_W'(1 << $urandom_range(0, MASK_W - 1));
    endfunction

    initial begin
        logic [ORDER_W-1:0] reversed;
        int                 count_pick;
        int                 n;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_POLICY_MODE;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        hold_request = 1'b0;
        masks_sent   = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: fixed priority over the identity order.
        offer_mask(8'h00);
        offer_mask(8'hFF);
        offer_mask(8'h01);
        offer_mask(8'h80);
        offer_mask(8'hAA);
        offer_mask(8'h55);

        // Round robin over the reversed order, starting in the middle.
        wait_idle();
        for (int i = 0; i < SLOT_LIMIT; i++)
            reversed[REQ_W*i +: REQ_W] = REQ_W'(SLOT_LIMIT - 1 - i);
        write_reg(CFG_POLICY_MODE, CFG_DATA_W'(POLICY_ROUND_ROBIN));
        write_reg(CFG_PRIORITY_ORDER, reversed);
        write_reg(CFG_RESET_CURSOR, 24'd3);
        offer_mask(8'hFF);
        offer_mask(8'hFF);
        offer_mask(8'hFF);
        offer_mask(8'h00);
        offer_mask(8'h81);

        // Three requesters; slot 0 names an out-of-range requester, slots 1 and 2
        // repeat one requester, and the cursor lies outside the count.
        wait_idle();
        write_reg(CFG_REQUESTER_COUNT, 24'd3);
        write_reg(CFG_PRIORITY_ORDER, 24'h00004D);
        write_reg(CFG_RESET_CURSOR, 24'd6);
        offer_mask(8'hFF);
        offer_mask(8'h23);
        offer_mask(8'h02);
        offer_mask(8'h01);

        // A count of zero behaves as one; junk above bit 0 of the policy write.
        wait_idle();
        write_reg(CFG_POLICY_MODE, 24'hABCDE0);
        write_reg(CFG_REQUESTER_COUNT, 24'd0);
        write_reg(CFG_PRIORITY_ORDER, ORDER_RESET);
        offer_mask(8'hFF);
        offer_mask(8'hFE);

        // A count of fifteen behaves as the full slot count.
        wait_idle();
        write_reg(CFG_REQUESTER_COUNT, 24'hFFFF0F);
        offer_mask(8'h80);
        offer_mask(8'h7F);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: count_pick = 1;
                1: count_pick = 8;
                2: count_pick = 0;
                3: count_pick = 15;
                4: count_pick = 2;
                5: count_pick = 8;
                default: count_pick = $urandom_range(0, 15);
            endcase
            n = (count_pick == 0) ? 1 : ((count_pick > SLOT_LIMIT) ? SLOT_LIMIT : count_pick);
            // Upper data bits are often random; the block keeps only each register's width.
            write_reg(CFG_POLICY_MODE, {(CFG_DATA_W - 1)'($urandom), ph[0]});
            write_reg(CFG_REQUESTER_COUNT,
                      {(CFG_DATA_W - COUNT_W)'($urandom), COUNT_W'(count_pick)}
                      & ((ph < 6) ? CFG_DATA_W'(4'hF) : '1));
            write_reg(CFG_PRIORITY_ORDER, make_order(n, $urandom_range(0, 2)));
            // Sometimes the cursor is carried over from the previous setting.
            if (ph < 2 || $urandom_range(0, 1) == 1)
                write_reg(CFG_RESET_CURSOR, CFG_DATA_W'($urandom));
            tx_idle_on = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == 2 && k == 16)
                    hold_request = 1'b1;
                offer_mask(random_mask());
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (grants_outstanding != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("sent %0d eligibility vectors over %0d random settings plus directed cases",
                 masks_sent, PHASES);
        $display("checked %0d results, %0d of them grants, %0d mismatches",
                 results_checked, grants_seen, mismatch_count);
        if (mismatch_count == 0 && grants_outstanding == 0) begin
            $display("permuted_priority_arbiter_unit_tb OK");
        end else begin
            $display("permuted_priority_arbiter_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
